// ===== rtl/core/lsps_pkg.sv =====
`default_nettype none

package lsps_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int MAX_DIM   = 4096;
  localparam int DIM_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int IN_W      = 56;
  localparam int OUT_W     = 32;
  localparam int REM_W     = 18;
  localparam int SIN_W     = 17;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BEAM_W    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FEATHER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_W     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_H     = 3'd7;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pix_t;

  typedef struct packed {
    logic full;
    logic ramp;
    logic core;
  } beam_flags_t;

  typedef logic [SIN_W-1:0] sin_lut_t [0:90];

  // sin(k deg) in Q30 by truncating Horner Taylor series, rounded to Q16
  function automatic logic [SIN_W-1:0] sin_q16(int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] m;
    x  = 64'(k) * 64'd18740330;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd156;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd110;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
    m  = (x * t) >> 30;
    m  = (m + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    return m[SIN_W-1:0];
  endfunction

  function automatic sin_lut_t build_sin();
    sin_lut_t l;
    for (int k = 0; k <= 90; k++) begin
      l[k] = sin_q16(k);
    end
    return l;
  endfunction

  localparam sin_lut_t SIN_LUT = build_sin();

  // angle 0..359 in whole degrees, result Q16
  function automatic logic signed [SIN_W:0] sin_deg(logic [8:0] ang);
    logic [1:0]       q;
    logic [8:0]       r;
    logic [6:0]       idx;
    logic [SIN_W-1:0] m;
    priority if (ang >= 9'd270) begin
      q = 2'd3;
      r = ang - 9'd270;
    end else if (ang >= 9'd180) begin
      q = 2'd2;
      r = ang - 9'd180;
    end else if (ang >= 9'd90) begin
      q = 2'd1;
      r = ang - 9'd90;
    end else begin
      q = 2'd0;
      r = ang;
    end
    idx = q[0] ? 7'(9'd90 - r) : r[6:0];
    m   = SIN_LUT[idx];
    return q[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // one restoring division step: {quotient bit, remainder}
  function automatic logic [REM_W:0] div_step(logic [REM_W-1:0] rem, logic b,
                                              logic [REM_W-1:0] d);
    logic [REM_W:0] sh;
    logic [REM_W:0] df;
    sh = {rem, b};
    df = sh - {1'b0, d};
    if (sh >= {1'b0, d}) begin
      return {1'b1, df[REM_W-1:0]};
    end
    return {1'b0, sh[REM_W-1:0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/light_sweep_pixel_shader.sv =====
`default_nettype none

// Light sweep pixel shader. Takes one RGBA pixel with its position per beat and
// returns the lit pixel: a straight beam at sweep_angle through sweep_center adds
// light_color, scaled by intensity and light alpha, to R,G,B with saturation.
// Pixels with alpha below 2 come out as all zeros. Throughput is one pixel per
// clock while the output is taken; the pipeline has 32 register stages, mostly
// the 28-bit position divider (2 bits per stage) and the 16-bit beam/core ramp
// dividers. The whole pipeline holds while the output beat is not taken. Write
// configuration only while the pipe is empty; register writes take effect
// through the registered derived constants.
module light_sweep_pixel_shader (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pixel_x, pixel_y, in_red, in_green, in_blue, in_alpha
  input  logic [lsps_pkg::IN_W-1:0]        s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [lsps_pkg::OUT_W-1:0]       m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                      cfg_data_i
);
  import lsps_pkg::*;

  localparam int NSTG  = 32;
  localparam int XSTG  = 14;
  localparam int ESTG  = 8;

  // configuration registers
  logic signed [8:0] center_q, angle_q;
  logic [7:0]        bw_q;
  logic [8:0]        inten_q;
  logic [6:0]        feather_q;
  logic [31:0]       color_q;
  logic [DIM_W-1:0]  imgw_q, imgh_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q  <= 9'sd50;
      angle_q   <= 9'sd35;
      bw_q      <= 8'd40;
      inten_q   <= 9'd100;
      feather_q <= 7'd50;
      color_q   <= 32'hFFFF_FFFF;
      imgw_q    <= 13'd1024;
      imgh_q    <= 13'd1024;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CENTER:    center_q  <= cfg_data_i[8:0];
        REG_ANGLE:     angle_q   <= cfg_data_i[8:0];
        REG_BEAM_W:    bw_q      <= cfg_data_i[7:0];
        REG_INTENSITY: inten_q   <= cfg_data_i[8:0];
        REG_FEATHER:   feather_q <= cfg_data_i[6:0];
        REG_COLOR:     color_q   <= cfg_data_i;
        REG_IMG_W:     imgw_q    <= cfg_data_i[DIM_W-1:0];
        REG_IMG_H:     imgh_q    <= cfg_data_i[DIM_W-1:0];
      endcase
    end
  end

  // derived constants, registered from the configuration registers
  logic [DIM_W-1:0]        wdim_q, hdim_q;
  logic [16:0]             halfw_q;
  logic signed [19:0]      pos_q;
  logic signed [SIN_W:0]   nx_q, ny_q;
  logic [23:0]             fprod_q;
  logic [15:0]             cw_q;
  logic [17:0]             fth_q;
  logic signed [18:0]      alo_q;
  logic [17:0]             ahi_q;
  logic [17:0]             twofth_q;

  logic [12:0]        bw17;
  logic [28:0]        bw17m;
  logic [16:0]        hw_raw;
  logic signed [9:0]  cn;
  logic [8:0]         can;
  logic [12:0]        can18;
  logic [28:0]        can18m;
  logic [19:0]        pmag;
  logic signed [9:0]  ang10;
  logic [8:0]         ang, ang2;
  logic [35:0]        cwm;
  logic [48:0]        fthm;
  logic [17:0]        fth_raw;

  always_comb begin
    bw17   = 13'(bw_q * 5'd17);
    bw17m  = bw17 * 16'd41944;
    hw_raw = 17'(bw_q * 9'd327) + 17'(bw17m[28:20]);
    cn     = 10'(center_q) - 10'sd50;
    can    = cn[9] ? 9'(-cn) : cn[8:0];
    can18  = 13'(can * 5'd18);
    can18m = can18 * 16'd41944;
    pmag   = 20'(can * 11'd1310) + 20'(can18m[28:20]);
    ang10  = 10'(angle_q) + (angle_q[8] ? 10'sd360 : 10'sd0);
    ang    = ang10[8:0];
    ang2   = (ang < 9'd270) ? ang + 9'd90 : ang - 9'd270;
    cwm    = {halfw_q, 1'b0} * 18'd209716;
    fthm   = fprod_q * 25'd21474837;
    fth_raw = fthm[48:31];
  end

  always_ff @(posedge clk_i) begin
    wdim_q   <= (imgw_q == '0) ? 13'd1 : (imgw_q > 13'(MAX_DIM)) ? 13'(MAX_DIM) : imgw_q;
    hdim_q   <= (imgh_q == '0) ? 13'd1 : (imgh_q > 13'(MAX_DIM)) ? 13'(MAX_DIM) : imgh_q;
    halfw_q  <= (hw_raw < 17'd66) ? 17'd66 : hw_raw;
    pos_q    <= cn[9] ? -$signed(pmag) : $signed(pmag);
    nx_q     <= -sin_deg(ang);
    ny_q     <= sin_deg(ang2);
    fprod_q  <= feather_q * halfw_q;
    cw_q     <= cwm[35:20];
    fth_q    <= (fth_raw < 18'd7) ? 18'd7 : fth_raw;
    alo_q    <= $signed({2'b00, halfw_q}) - $signed({1'b0, fth_q});
    ahi_q    <= 18'(halfw_q) + fth_q;
    twofth_q <= {fth_q[16:0], 1'b0};
  end

  // pipeline control
  logic [NSTG-1:0] vld_q;
  logic            adv;

  assign adv           = !vld_q[NSTG-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  // pixel color carried alongside
  pix_t pix_q [0:NSTG-2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pix_q[0] <= s_axis_tdata[55:24];
    end
  end

  for (genvar j = 1; j <= NSTG-2; j++) begin : g_pix
    always_ff @(posedge clk_i) begin
      if (adv) begin
        pix_q[j] <= pix_q[j-1];
      end
    end
  end

  // position dividers: (p << 16) / dim, two quotient bits per stage
  logic [REM_W-1:0] xr_q [0:XSTG];
  logic [REM_W-1:0] yr_q [0:XSTG];
  logic [27:0]      xn_q [0:XSTG];
  logic [27:0]      yn_q [0:XSTG];
  logic [27:0]      xq_q [0:XSTG];
  logic [27:0]      yq_q [0:XSTG];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xr_q[0] <= '0;
      yr_q[0] <= '0;
      xn_q[0] <= {s_axis_tdata[11:0], 16'd0};
      yn_q[0] <= {s_axis_tdata[23:12], 16'd0};
      xq_q[0] <= '0;
      yq_q[0] <= '0;
    end
  end

  for (genvar j = 1; j <= XSTG; j++) begin : g_xdiv
    logic [REM_W:0] xa, xb, ya, yb;
    always_comb begin
      xa = div_step(xr_q[j-1], xn_q[j-1][27], REM_W'(wdim_q));
      xb = div_step(xa[REM_W-1:0], xn_q[j-1][26], REM_W'(wdim_q));
      ya = div_step(yr_q[j-1], yn_q[j-1][27], REM_W'(hdim_q));
      yb = div_step(ya[REM_W-1:0], yn_q[j-1][26], REM_W'(hdim_q));
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        xr_q[j] <= xb[REM_W-1:0];
        yr_q[j] <= yb[REM_W-1:0];
        xn_q[j] <= {xn_q[j-1][25:0], 2'b00};
        yn_q[j] <= {yn_q[j-1][25:0], 2'b00};
        xq_q[j] <= {xq_q[j-1][25:0], xa[REM_W], xb[REM_W]};
        yq_q[j] <= {yq_q[j-1][25:0], ya[REM_W], yb[REM_W]};
      end
    end
  end

  // projection onto the sweep normal
  logic signed [28:0] uvx, uvy;
  logic signed [46:0] prodx_q, prody_q;
  logic signed [47:0] psum;
  logic signed [31:0] proj_q;

  assign uvx  = $signed({1'b0, xq_q[XSTG]}) - 29'sd32768;
  assign uvy  = $signed({1'b0, yq_q[XSTG]}) - 29'sd32768;
  assign psum = prodx_q + prody_q + 48'sd32768;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prodx_q <= uvx * nx_q;
      prody_q <= uvy * ny_q;
      proj_q  <= psum[47:16];
    end
  end

  // distance to the sweep line and ramp divider setup
  logic signed [32:0] diff;
  logic [32:0]        dabs;
  logic signed [34:0] bnum;
  beam_flags_t        fl_d;

  always_comb begin
    diff      = proj_q - pos_q;
    dabs      = diff[32] ? 33'(-diff) : diff;
    bnum      = $signed({2'b00, dabs}) - alo_q;
    fl_d.full = $signed({1'b0, dabs}) < alo_q;
    fl_d.ramp = (dabs < 33'(ahi_q)) && !fl_d.full;
    fl_d.core = dabs < 33'(cw_q);
  end

  logic [REM_W-1:0] br_q [0:ESTG];
  logic [REM_W-1:0] cr_q [0:ESTG];
  logic [15:0]      bq_q [0:ESTG];
  logic [15:0]      cq_q [0:ESTG];
  beam_flags_t      fl_q [0:ESTG];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      br_q[0] <= fl_d.ramp ? bnum[REM_W-1:0] : '0;
      cr_q[0] <= fl_d.core ? dabs[REM_W-1:0] : '0;
      bq_q[0] <= '0;
      cq_q[0] <= '0;
      fl_q[0] <= fl_d;
    end
  end

  for (genvar j = 1; j <= ESTG; j++) begin : g_ediv
    logic [REM_W:0] ba, bb, ca, cb;
    always_comb begin
      ba = div_step(br_q[j-1], 1'b0, twofth_q);
      bb = div_step(ba[REM_W-1:0], 1'b0, twofth_q);
      ca = div_step(cr_q[j-1], 1'b0, REM_W'(cw_q));
      cb = div_step(ca[REM_W-1:0], 1'b0, REM_W'(cw_q));
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        br_q[j] <= bb[REM_W-1:0];
        cr_q[j] <= cb[REM_W-1:0];
        bq_q[j] <= {bq_q[j-1][13:0], ba[REM_W], bb[REM_W]};
        cq_q[j] <= {cq_q[j-1][13:0], ca[REM_W], cb[REM_W]};
        fl_q[j] <= fl_q[j-1];
      end
    end
  end

  // light value: (beam + core) * intensity * alpha / 25500
  logic [16:0] beam, core;
  logic [17:0] bsum;
  logic [16:0] cdiff;
  logic [26:0] p1_q;
  logic [34:0] p2_q, p2b_q, p2c_q;
  logic [54:0] qem;
  logic [20:0] qe_q, qe2_q;
  logic [35:0] qprod_q;
  logic [35:0] rem36;
  logic [18:0] lv_q;

  always_comb begin
    cdiff = 17'(ONE) - 17'(cq_q[ESTG]);
    beam  = fl_q[ESTG].full ? 17'(ONE) :
            fl_q[ESTG].ramp ? 17'(ONE) - 17'(bq_q[ESTG]) : 17'd0;
    core  = fl_q[ESTG].core ? (cdiff >> 1) : 17'd0;
    bsum  = 18'(beam) + 18'(core);
    qem   = p2_q * 20'd673720;
    rem36 = 36'(p2c_q) - qprod_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q    <= bsum * inten_q;
      p2_q    <= p1_q * color_q[7:0];
      qe_q    <= qem[54:34];
      p2b_q   <= p2_q;
      qprod_q <= qe_q * 15'd25500;
      qe2_q   <= qe_q;
      p2c_q   <= p2b_q;
      lv_q    <= 19'(qe2_q + ((rem36 >= 36'd25500) ? 21'd1 : 21'd0));
    end
  end

  // add light and saturate; pixels with alpha below 2 are zeroed
  pix_t        src, out_q;
  logic [26:0] lr, lg, lb;
  logic [11:0] vr, vg, vb;

  always_comb begin
    src = pix_q[NSTG-2];
    lr  = color_q[31:24] * lv_q;
    lg  = color_q[23:16] * lv_q;
    lb  = color_q[15:8]  * lv_q;
    vr  = 12'(src.r) + 12'(lr[26:16]);
    vg  = 12'(src.g) + 12'(lg[26:16]);
    vb  = 12'(src.b) + 12'(lb[26:16]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (src.a < 8'd2) begin
        out_q <= '0;
      end else begin
        out_q.r <= (vr > 12'd255) ? 8'd255 : vr[7:0];
        out_q.g <= (vg > 12'd255) ? 8'd255 : vg[7:0];
        out_q.b <= (vb > 12'd255) ? 8'd255 : vb[7:0];
        out_q.a <= src.a;
      end
    end
  end

  assign m_axis_tdata = out_q;

`ifndef NO_ASSERTIONS
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted beat did not enter pipeline");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vld_q[NSTG-1]) |-> $past(vld_q[NSTG-2]))
    else $error("output valid without a preceding stage");

  a_alpha_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[31:24] != 8'd1))
    else $error("alpha of one must be cleared");

  a_clear_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[31:24] == 8'd0)) |-> (m_axis_tdata[23:0] == 24'd0))
    else $error("transparent pixel not zeroed");
`endif

endmodule

`default_nettype wire
